// ===== hdl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI engine package
// Shared request/result types, codes and constants.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned WriteBlockBytes = 512;
  localparam int unsigned WbW = $clog2(WriteBlockBytes + 1);
  // byte counter covers both the write block and a full 10-bit read length
  localparam int unsigned CntW = (WbW > 10) ? WbW : 10;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_XFER  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_CMD_RD = 3'd1;
  localparam logic [2:0] OP_CMD_WR = 3'd2;
  localparam logic [2:0] OP_RD     = 3'd3;
  localparam logic [2:0] OP_WR     = 3'd4;
  localparam logic [2:0] OP_DESEL  = 3'd5;

  localparam logic [1:0] CFG_READY_TO = 2'd0;
  localparam logic [1:0] CFG_TOKEN_TO = 2'd1;
  localparam logic [1:0] CFG_POLLS    = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RDY  = 3'd1;
  localparam logic [2:0] ST_BAD_RESP = 3'd2;
  localparam logic [2:0] ST_TOKEN    = 3'd3;
  localparam logic [2:0] ST_WR_REJ   = 3'd4;
  localparam logic [2:0] ST_PREFIX   = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  op;
    logic [5:0]  cmd_index;
    logic        app_cmd;
    logic [31:0] argument;
    logic [9:0]  data_length;
    logic [7:0]  data_token;
    logic [7:0]  card_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       chip_select_high;
    logic       want_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] response;
  } res_t;

  typedef struct packed {
    logic [9:0] ready_to;
    logic [9:0] token_to;
    logic [7:0] polls;
  } cfg_t;

endpackage

// ===== hdl/sdspi_front.sv =====
// ----------------------------------------------------------------------------
// SD SPI front
// Holds configuration registers and a short request queue feeding the engine.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              push,
  output logic              full,
  input  sdspi_pkg::req_t   req,
  output logic              q_valid,
  input  logic              q_take,
  output sdspi_pkg::req_t   q_req,
  output sdspi_pkg::cfg_t   cfg
);
  sdspi_pkg::req_t slot [sdspi_pkg::QDepth];
  logic [sdspi_pkg::QCntW-1:0] cnt;
  logic [sdspi_pkg::QPtrW-1:0] wp, rp;
  logic do_push, do_pop;

  assign full = (cnt == sdspi_pkg::QCntW'(sdspi_pkg::QDepth));
  assign q_valid = (cnt != '0);
  assign q_req = slot[rp];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp <= '0;
      rp <= '0;
      cfg <= '{ready_to: 10'd500, token_to: 10'd100, polls: 8'd10};
    end else begin
      if (do_push) begin
        wp <= (wp == sdspi_pkg::QPtrW'(sdspi_pkg::QDepth - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == sdspi_pkg::QPtrW'(sdspi_pkg::QDepth - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + sdspi_pkg::QCntW'(do_push) - sdspi_pkg::QCntW'(do_pop);
      if (cfg_we) begin
        unique case (cfg_index)
          sdspi_pkg::CFG_READY_TO: cfg.ready_to <= cfg_data;
          sdspi_pkg::CFG_TOKEN_TO: cfg.token_to <= cfg_data;
          sdspi_pkg::CFG_POLLS:    cfg.polls <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    if (do_push) slot[wp] <= req;
  end
endmodule

// ===== hdl/sdspi_back.sv =====
// ----------------------------------------------------------------------------
// SD SPI back
// Sequencer that turns each request into one result, with an output queue.
// ----------------------------------------------------------------------------
module sdspi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_take,
  input  sdspi_pkg::req_t   q_req,
  input  sdspi_pkg::cfg_t   cfg,
  output logic              empty,
  input  logic              pop,
  output sdspi_pkg::res_t   res
);
  typedef enum logic [4:0] {
    PH_IDLE, PH_DESEL, PH_RDY_DUMMY, PH_RDY_POLL, PH_SEL_FAIL, PH_CMD,
    PH_STUFF, PH_RESP, PH_TOK_POLL, PH_RD_DATA, PH_RD_CRC, PH_W_TOKEN,
    PH_W_DATA, PH_W_CRC, PH_W_RESP, PH_DESEL_OP
  } phase_t;

  phase_t phase, phase_next;
  logic [sdspi_pkg::CntW-1:0] byte_count, byte_count_next;
  logic [9:0] ready_timer, ready_timer_next, token_timer, token_timer_next;
  logic [7:0] poll_count, poll_count_next;
  logic [5:0] saved_command, saved_command_next;
  logic [31:0] saved_argument, saved_argument_next;
  logic [2:0] saved_op, saved_op_next;
  logic [9:0] saved_length, saved_length_next;
  logic [7:0] saved_token, saved_token_next;
  logic [7:0] last_response, last_response_next;
  logic cs_high, cs_high_next, in_prefix, in_prefix_next, writing, writing_next;

  sdspi_pkg::res_t oq [sdspi_pkg::QDepth];
  logic [sdspi_pkg::QCntW-1:0] ocnt;
  logic [sdspi_pkg::QPtrW-1:0] owp, orp;
  logic opop;
  sdspi_pkg::res_t r;

  logic [7:0] b, wb;
  logic [5:0] cc;
  logic [31:0] ca;

  assign q_take = q_valid && (ocnt != sdspi_pkg::QCntW'(sdspi_pkg::QDepth));
  assign empty = (ocnt == '0);
  assign res = oq[orp];
  assign opop = pop && !empty;
  assign b = q_req.card_byte;
  assign wb = q_req.write_byte;
  assign cc = in_prefix ? 6'd55 : saved_command;
  assign ca = in_prefix ? 32'd0 : saved_argument;

  function automatic logic [7:0] frame(input logic [2:0] k, input logic [5:0] c,
                                       input logic [31:0] a);
    logic [7:0] v;
    unique case (k)
      3'd0: v = {2'b01, c};
      3'd1: v = a[31:24];
      3'd2: v = a[23:16];
      3'd3: v = a[15:8];
      3'd4: v = a[7:0];
      default: v = (c == 6'd0) ? 8'h95 : ((c == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return v;
  endfunction

  always_comb begin
    phase_next = phase; byte_count_next = byte_count;
    ready_timer_next = ready_timer; token_timer_next = token_timer;
    poll_count_next = poll_count; saved_command_next = saved_command;
    saved_argument_next = saved_argument; saved_op_next = saved_op;
    saved_length_next = saved_length; saved_token_next = saved_token;
    last_response_next = last_response; cs_high_next = cs_high;
    in_prefix_next = in_prefix; writing_next = writing;
    r = '0;
    // result fields taken after state update; flags set below
    begin : seq
      logic sv, wt, rv, dn;
      logic [7:0] sb, rb;
      logic [2:0] st;
      sv = 1'b0; wt = 1'b0; rv = 1'b0; dn = 1'b0; sb = '0; rb = '0; st = '0;
      if (q_req.req_type == sdspi_pkg::REQ_TICK) begin
        if (ready_timer != 0) ready_timer_next = ready_timer - 10'd1;
        if (token_timer != 0) token_timer_next = token_timer - 10'd1;
      end else if (q_req.req_type == sdspi_pkg::REQ_START) begin
        if (phase == PH_IDLE) begin
          saved_op_next = q_req.op;
          saved_command_next = q_req.cmd_index;
          in_prefix_next = 1'b0;
          saved_argument_next = q_req.argument;
          saved_length_next = q_req.data_length;
          saved_token_next = q_req.data_token;
          writing_next = 1'b0;
          sv = 1'b1; sb = 8'hFF;
          unique case (q_req.op)
            sdspi_pkg::OP_CMD, sdspi_pkg::OP_CMD_RD, sdspi_pkg::OP_CMD_WR: begin
              in_prefix_next = q_req.app_cmd; cs_high_next = 1'b1; phase_next = PH_DESEL;
            end
            sdspi_pkg::OP_RD: begin
              token_timer_next = cfg.token_to; phase_next = PH_TOK_POLL;
            end
            sdspi_pkg::OP_WR: begin
              writing_next = 1'b1; ready_timer_next = cfg.ready_to;
              phase_next = PH_RDY_DUMMY;
            end
            sdspi_pkg::OP_DESEL: begin cs_high_next = 1'b1; phase_next = PH_DESEL_OP; end
            default: begin sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE; end
          endcase
        end
      end else if (q_req.req_type == sdspi_pkg::REQ_XFER && phase != PH_IDLE) begin
        sv = 1'b1; sb = 8'hFF;
        unique case (phase)
          PH_DESEL: begin
            cs_high_next = 1'b0; ready_timer_next = cfg.ready_to; phase_next = PH_RDY_DUMMY;
          end
          PH_RDY_DUMMY: phase_next = PH_RDY_POLL;
          PH_RDY_POLL: begin
            if (b == 8'hFF) begin
              if (writing) begin
                phase_next = PH_W_TOKEN; sb = saved_token; wt = (saved_token != 8'hFD);
              end else begin
                phase_next = PH_CMD; byte_count_next = '0; sb = frame(3'd0, cc, ca);
              end
            end else if (ready_timer == 0) begin
              if (writing) begin
                sv = 1'b0; sb = '0; dn = 1'b1; st = sdspi_pkg::ST_NOT_RDY;
                phase_next = PH_IDLE;
              end else begin
                cs_high_next = 1'b1; phase_next = PH_SEL_FAIL;
              end
            end
          end
          PH_SEL_FAIL: begin
            last_response_next = 8'hFF; sv = 1'b0; sb = '0; dn = 1'b1;
            st = in_prefix ? sdspi_pkg::ST_PREFIX : sdspi_pkg::ST_NOT_RDY;
            phase_next = PH_IDLE;
          end
          PH_CMD: begin
            byte_count_next = byte_count + 1'b1;
            if (byte_count < 5) sb = frame(3'(byte_count + 1'b1), cc, ca);
            else begin
              poll_count_next = (cfg.polls != 0) ? cfg.polls : 8'd1;
              phase_next = (cc == 6'd12) ? PH_STUFF : PH_RESP;
            end
          end
          PH_STUFF: phase_next = PH_RESP;
          PH_RESP: begin
            if (b[7] && poll_count > 1) poll_count_next = poll_count - 8'd1;
            else begin
              last_response_next = b;
              if (in_prefix) begin
                if (b > 8'd1) begin
                  sv = 1'b0; sb = '0; dn = 1'b1; st = sdspi_pkg::ST_PREFIX;
                  phase_next = PH_IDLE;
                end else begin
                  in_prefix_next = 1'b0; cs_high_next = 1'b1; phase_next = PH_DESEL;
                end
              end else if (saved_op == sdspi_pkg::OP_CMD || b != 0) begin
                sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE;
                st = (saved_op == sdspi_pkg::OP_CMD && !b[7]) ? sdspi_pkg::ST_OK
                                                             : sdspi_pkg::ST_BAD_RESP;
              end else if (saved_op == sdspi_pkg::OP_CMD_RD) begin
                token_timer_next = cfg.token_to; phase_next = PH_TOK_POLL;
              end else begin
                writing_next = 1'b1; ready_timer_next = cfg.ready_to;
                phase_next = PH_RDY_DUMMY;
              end
            end
          end
          PH_TOK_POLL: begin
            if (!(b == 8'hFF && token_timer != 0)) begin
              if (b != 8'hFE) begin
                sv = 1'b0; sb = '0; dn = 1'b1; st = sdspi_pkg::ST_TOKEN;
                phase_next = PH_IDLE;
              end else begin
                byte_count_next = '0;
                phase_next = (saved_length != 0) ? PH_RD_DATA : PH_RD_CRC;
              end
            end
          end
          PH_RD_DATA: begin
            rv = 1'b1; rb = b;
            byte_count_next = byte_count + 1'b1;
            if ((byte_count + 1'b1) >= sdspi_pkg::CntW'(saved_length)) begin
              phase_next = PH_RD_CRC; byte_count_next = '0;
            end
          end
          PH_RD_CRC: begin
            byte_count_next = byte_count + 1'b1;
            if (byte_count != 0) begin
              sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE;
            end
          end
          PH_W_TOKEN: begin
            if (saved_token == 8'hFD) begin
              sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE;
            end else begin
              byte_count_next = sdspi_pkg::CntW'(1); phase_next = PH_W_DATA; sb = wb;
              wt = (1 < sdspi_pkg::WriteBlockBytes);
            end
          end
          PH_W_DATA: begin
            if (byte_count < sdspi_pkg::CntW'(sdspi_pkg::WriteBlockBytes)) begin
              byte_count_next = byte_count + 1'b1; sb = wb;
              wt = ((byte_count + 1'b1) < sdspi_pkg::CntW'(sdspi_pkg::WriteBlockBytes));
            end else begin
              phase_next = PH_W_CRC; byte_count_next = '0;
            end
          end
          PH_W_CRC: begin
            byte_count_next = byte_count + 1'b1;
            if (byte_count != 0) phase_next = PH_W_RESP;
          end
          PH_W_RESP: begin
            sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE;
            st = (b[4:0] == 5'h05) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_WR_REJ;
          end
          PH_DESEL_OP: begin sv = 1'b0; sb = '0; dn = 1'b1; phase_next = PH_IDLE; end
          default: begin sv = 1'b0; sb = '0; phase_next = PH_IDLE; end
        endcase
      end
      r.send_valid = sv; r.send_byte = sb; r.chip_select_high = cs_high_next;
      r.want_write_byte = wt; r.read_valid = rv; r.read_byte = rb;
      r.done_res = dn; r.status = st; r.response = last_response_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; byte_count <= '0; ready_timer <= '0; token_timer <= '0;
      poll_count <= '0; saved_command <= '0; saved_argument <= '0; saved_op <= '0;
      saved_length <= '0; saved_token <= '0; last_response <= 8'hFF;
      cs_high <= 1'b1; in_prefix <= 1'b0; writing <= 1'b0;
      ocnt <= '0; owp <= '0; orp <= '0;
    end else begin
      if (q_take) begin
        phase <= phase_next; byte_count <= byte_count_next;
        ready_timer <= ready_timer_next; token_timer <= token_timer_next;
        poll_count <= poll_count_next; saved_command <= saved_command_next;
        saved_argument <= saved_argument_next; saved_op <= saved_op_next;
        saved_length <= saved_length_next; saved_token <= saved_token_next;
        last_response <= last_response_next; cs_high <= cs_high_next;
        in_prefix <= in_prefix_next; writing <= writing_next;
        owp <= (owp == sdspi_pkg::QPtrW'(sdspi_pkg::QDepth - 1)) ? '0 : owp + 1'b1;
      end
      if (opop) begin
        orp <= (orp == sdspi_pkg::QPtrW'(sdspi_pkg::QDepth - 1)) ? '0 : orp + 1'b1;
      end
      ocnt <= ocnt + sdspi_pkg::QCntW'(q_take) - sdspi_pkg::QCntW'(opop);
    end
    if (q_take) oq[owp] <= r;
  end
endmodule

// ===== hdl/sd_spi_command_block_engine_core.sv =====
// ----------------------------------------------------------------------------
// SD SPI command/block engine
// Host engine for an SD card in SPI mode, one byte exchange per request.
// ----------------------------------------------------------------------------
// Usage: push a request (start, exchange completed, or 1 ms tick) while full
// is low. Each request yields exactly one result, read while empty is low
// and taken with pop. A result names the next byte to exchange, chip select,
// read payload, or completion status with the last R1 byte.
// Flow: a request enters a two-entry input queue, the sequencer handles
// one request per cycle from it while the output queue has room, and the
// result is written into a two-entry output queue when the sequencer takes
// the request. Sustained rate is one request per cycle, set by the single
// sequencer step, as long as the result side does not stall.
// When the result side stalls, the output queue fills, the sequencer holds,
// then the input queue fills and full rises.
// Reset clears both queues, returns the sequencer to idle, and loads the
// timeouts 500 ms and 100 ms and 10 response polls. Configuration writes
// (we, index, data) take effect on the next edge.
// ----------------------------------------------------------------------------
module sd_spi_command_block_engine_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [1:0]        index,
  input  logic [9:0]        data,
  input  logic              push,
  output logic              full,
  input  sdspi_pkg::req_t   req,
  output logic              empty,
  input  logic              pop,
  output sdspi_pkg::res_t   res
);
  logic q_valid, q_take;
  sdspi_pkg::req_t q_req;
  sdspi_pkg::cfg_t cfg;

  sdspi_front u_front (
    .clk, .rst, .cfg_we(we), .cfg_index(index), .cfg_data(data),
    .push, .full, .req, .q_valid, .q_take, .q_req, .cfg
  );

  sdspi_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_req, .cfg, .empty, .pop, .res
  );

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take without queued request");
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.done_res) |-> !res.send_valid) else $error("done with send");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !q_take) |=> full) else $error("full dropped without take");
endmodule
